// ===== hdl/text_mode_console_writer_unit_assert.svh =====
// Assertion macros for the RTL of the console writer.
`ifndef TEXT_MODE_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TMCW_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tmcw assertion failed");
`define TMCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmcw assertion failed");
`else
`define TMCW_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TMCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/tmcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int CELL_W  = 16;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'd7;
    localparam logic [CELL_W-1:0] BLANK_RESET  = {RESET_COLOR, BLANK_CODE};

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL
    } t_state;

    typedef struct packed {
        logic clear_en;
        logic put_en;
        logic scroll_start;
        logic read_en;
        logic read_load;
        logic scroll_en;
        logic scroll_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_scroll;
        logic clear_last;
        logic scroll_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/tmcw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/tmcw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmcw_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_action,
    input  wire tmcw_pkg::t_dp_status i_status,
    output tmcw_pkg::t_dp_cmd         o_cmd,
    output logic                      o_busy
);

    import tmcw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_action == ACT_READ) begin
                        o_cmd.read_en = 1'b1;
                        n_state       = S_READ;
                    end else begin
                        o_cmd.put_en = 1'b1;
                        if (i_status.need_scroll) begin
                            o_cmd.scroll_start = 1'b1;
                            n_state            = S_SCROLL;
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.read_load = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCROLL: begin
                o_cmd.scroll_en = 1'b1;
                if (i_status.scroll_last) begin
                    o_cmd.scroll_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tmcw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "text_mode_console_writer_unit_assert.svh"

module tmcw_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tmcw_pkg::t_dp_cmd               i_cmd,
    output tmcw_pkg::t_dp_status                 o_status,
    input  wire logic                            i_cfg_we,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]     i_cfg_data,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [tmcw_pkg::IDX_W-1:0]      i_cell_index,
    output logic                                 o_strobe,
    output logic      [tmcw_pkg::COL_W-1:0]      o_cursor_column,
    output logic      [tmcw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic                                 o_scrolled,
    output logic      [tmcw_pkg::CELL_W-1:0]     o_read_cell
);

    import tmcw_pkg::*;

    logic [CHAR_W-1:0] r_color;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_in_range;

    logic              r_strobe;
    logic [COL_W-1:0]  r_res_col;
    logic [ROW_W-1:0]  r_res_row;
    logic              r_res_scrolled;
    logic [CELL_W-1:0] r_res_cell;

    logic [COL_W:0]    w_col_inc;
    logic [ROW_W:0]    w_row_inc;
    logic [ROW_W:0]    w_row_tmp;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic              w_need_scroll;
    logic              w_is_newline;
    logic [ADDR_W-1:0] w_cur_addr;
    logic [CNT_W-1:0]  w_cnt_dec;
    logic [CNT_W:0]    w_src;
    logic              w_idx_ok;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [CELL_W-1:0] w_rdata;

    logic              w_scroll_report;
    logic              w_last_row;
    logic              w_cell_report;

    assign w_is_newline = (i_char_code == NEWLINE_CODE);
    assign w_col_inc    = {1'b0, r_col} + 1'b1;
    assign w_row_inc    = {1'b0, r_row} + 1'b1;

    always_comb begin
        n_col     = r_col;
        w_row_tmp = {1'b0, r_row};
        if (w_is_newline) begin
            n_col     = '0;
            w_row_tmp = w_row_inc;
        end else if (32'(w_col_inc) >= COLUMNS) begin
            n_col     = '0;
            w_row_tmp = w_row_inc;
        end else begin
            n_col = w_col_inc[COL_W-1:0];
        end
        w_need_scroll = (32'(w_row_tmp) >= ROWS);
        n_row = w_need_scroll ? ROW_W'(ROWS - 1) : w_row_tmp[ROW_W-1:0];
    end

    assign w_cur_addr = ADDR_W'(32'(r_row) * COLUMNS + 32'(r_col));
    assign w_cnt_dec  = r_cnt - 1'b1;
    assign w_src      = {1'b0, r_cnt} + (CNT_W + 1)'(COLUMNS);
    assign w_idx_ok   = (32'(i_cell_index) < CELLS);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_cur_addr;
        w_wdata = {r_color, i_char_code};
        w_raddr = '0;
        if (i_cmd.clear_en) begin
            w_we    = 1'b1;
            w_waddr = r_cnt[ADDR_W-1:0];
            w_wdata = BLANK_RESET;
        end else if (i_cmd.put_en) begin
            w_we = !w_is_newline;
        end else if (i_cmd.scroll_en) begin
            w_we    = (r_cnt != '0);
            w_waddr = w_cnt_dec[ADDR_W-1:0];
            w_wdata = (32'(w_cnt_dec) < CELLS - COLUMNS) ? w_rdata : {r_color, BLANK_CODE};
            if (32'(w_src) < CELLS) begin
                w_raddr = w_src[ADDR_W-1:0];
            end
        end else if (i_cmd.read_en) begin
            if (w_idx_ok) begin
                w_raddr = i_cell_index[ADDR_W-1:0];
            end
        end
    end

    tmcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color  <= RESET_COLOR;
            r_col    <= '0;
            r_row    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.put_en && !w_need_scroll) || i_cmd.read_load ||
                        i_cmd.scroll_load;
            if (i_cfg_we) begin
                r_color <= i_cfg_data;
            end
            if (i_cmd.clear_en || i_cmd.scroll_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.scroll_start) begin
                r_cnt <= '0;
            end
            if (i_cmd.put_en) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_en) begin
            r_rd_in_range <= w_idx_ok;
        end
        if (i_cmd.put_en) begin
            r_res_col      <= n_col;
            r_res_row      <= n_row;
            r_res_scrolled <= 1'b0;
            r_res_cell     <= '0;
        end
        if (i_cmd.read_load) begin
            r_res_col      <= r_col;
            r_res_row      <= r_row;
            r_res_scrolled <= 1'b0;
            r_res_cell     <= r_rd_in_range ? w_rdata : '0;
        end
        if (i_cmd.scroll_load) begin
            r_res_col      <= r_col;
            r_res_row      <= r_row;
            r_res_scrolled <= 1'b1;
            r_res_cell     <= '0;
        end
    end

    assign o_status.need_scroll = w_need_scroll;
    assign o_status.clear_last  = (r_cnt == CNT_W'(CELLS - 1));
    assign o_status.scroll_last = (r_cnt == CNT_W'(CELLS));

    assign o_strobe        = r_strobe;
    assign o_cursor_column = r_res_col;
    assign o_cursor_row    = r_res_row;
    assign o_scrolled      = r_res_scrolled;
    assign o_read_cell     = r_res_cell;

    assign w_scroll_report = r_strobe && r_res_scrolled;
    assign w_last_row      = (r_res_row == ROW_W'(ROWS - 1));
    assign w_cell_report   = r_strobe && (r_res_cell != '0);

    `TMCW_ASSERT_ALWAYS(a_row_in_range, i_clk, i_rst_n, 32'(r_row) < ROWS)
    `TMCW_ASSERT_ALWAYS(a_col_in_range, i_clk, i_rst_n, 32'(r_col) < COLUMNS)
    `TMCW_ASSERT_IMPLY(a_scroll_row, i_clk, i_rst_n, w_scroll_report, w_last_row)
    `TMCW_ASSERT_IMPLY(a_cell_from_read, i_clk, i_rst_n, w_cell_report, $past(i_cmd.read_load))

endmodule

`default_nettype wire

// ===== hdl/text_mode_console_writer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text-mode console writer for an 80 by 25 screen of 16-bit cells. After reset the block is
// busy while it blanks the screen memory. An item is taken when start is high and busy is
// low; each item yields one result, shown for one cycle with o_strobe high, and the receiver
// cannot stall it, so it must take every strobe. The result of a put that does not scroll
// appears the cycle after it is taken, and busy stays low so puts can follow every cycle. A
// read passes through the read state, as the read of the screen memory is registered; busy is
// high meanwhile. A put that scrolls keeps busy high while the memory is swept once, one cell
// moved per cycle, and the bottom row is filled with blanks; its result follows at the end.
// The colour register may be written at any time but should change only while the block is idle.

module text_mode_console_writer_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_action,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [tmcw_pkg::IDX_W-1:0]      i_cell_index,
    output logic                                 o_strobe,
    output logic      [tmcw_pkg::COL_W-1:0]      o_cursor_column,
    output logic      [tmcw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic                                 o_scrolled,
    output logic      [tmcw_pkg::CELL_W-1:0]     o_read_cell,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]     i_cfg_data
);

    import tmcw_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    tmcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    tmcw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .o_strobe        (o_strobe),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_scrolled      (o_scrolled),
        .o_read_cell     (o_read_cell)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tmcw_pkg::*;

    localparam int QUIET_LIMIT = 12000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 285;
    localparam int ROWS_DIRECTED = 20;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scrolled;
        logic [CELL_W-1:0] rd_cell;
    } t_cursor_report;

    typedef struct packed {
        logic              act;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic              typed;
        t_cursor_report    want;
    } t_console_request;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_action = ACT_PUT;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic [IDX_W-1:0]  i_cell_index = '0;
    logic              o_strobe;
    logic [COL_W-1:0]  o_cursor_column;
    logic [ROW_W-1:0]  o_cursor_row;
    logic              o_scrolled;
    logic [CELL_W-1:0] o_read_cell;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CHAR_W-1:0] i_cfg_data = '0;

    logic [CELL_W-1:0] screen_cells [0:CELLS-1];
    int                cursor_col;
    int                cursor_line;
    logic [CHAR_W-1:0] text_colour;

    t_cursor_report    console_reports_due [$];
    t_cursor_report    oldest_report;
    int                fail_count = 0;
    int                quiet_cycles = 0;
    int                idle_pct = 32;

    t_console_request directed_requests [0:ROWS_DIRECTED-1] = '{
        '{ACT_READ, 8'h00, 11'd0,    1'b1, '{7'd0, 5'd0, 1'b0, BLANK_RESET}},
        '{ACT_READ, 8'h00, 11'd1999, 1'b1, '{7'd0, 5'd0, 1'b0, BLANK_RESET}},
        '{ACT_READ, 8'h00, 11'd2000, 1'b1, '{7'd0, 5'd0, 1'b0, 16'h0000}},
        '{ACT_READ, 8'hFF, 11'd2047, 1'b1, '{7'd0, 5'd0, 1'b0, 16'h0000}},
        '{ACT_PUT,  8'h41, 11'd2047, 1'b1, '{7'd1, 5'd0, 1'b0, 16'h0000}},
        '{ACT_PUT,  8'h00, 11'd0,    1'b1, '{7'd2, 5'd0, 1'b0, 16'h0000}},
        '{ACT_PUT,  8'hFF, 11'd1000, 1'b1, '{7'd3, 5'd0, 1'b0, 16'h0000}},
        '{ACT_READ, NEWLINE_CODE, 11'd0, 1'b1, '{7'd3, 5'd0, 1'b0, 16'h0741}},
        '{ACT_READ, 8'h00, 11'd1,    1'b1, '{7'd3, 5'd0, 1'b0, 16'h0700}},
        '{ACT_READ, 8'h00, 11'd2,    1'b1, '{7'd3, 5'd0, 1'b0, 16'h07FF}},
        '{ACT_PUT,  NEWLINE_CODE, 11'd5, 1'b1, '{7'd0, 5'd1, 1'b0, 16'h0000}},
        '{ACT_READ, 8'h00, 11'd3,    1'b1, '{7'd0, 5'd1, 1'b0, BLANK_RESET}},
        '{ACT_PUT,  NEWLINE_CODE, 11'd0, 1'b1, '{7'd0, 5'd2, 1'b0, 16'h0000}},
        '{ACT_PUT,  BLANK_CODE, 11'd0, 1'b1, '{7'd1, 5'd2, 1'b0, 16'h0000}},
        '{ACT_PUT,  8'h7F, 11'd0,    1'b1, '{7'd2, 5'd2, 1'b0, 16'h0000}},
        '{ACT_READ, 8'h00, 11'd160,  1'b1, '{7'd2, 5'd2, 1'b0, BLANK_RESET}},
        '{ACT_READ, 8'h00, 11'd161,  1'b1, '{7'd2, 5'd2, 1'b0, 16'h077F}},
        '{ACT_PUT,  8'h80, 11'd1999, 1'b0, '0},
        '{ACT_READ, 8'h00, 11'd162,  1'b0, '0},
        '{ACT_READ, 8'h00, 11'd80,   1'b0, '0}
    };

    text_mode_console_writer_unit uut (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_cursor_report advance_console(input logic act,
                                                       input logic [CHAR_W-1:0] ch,
                                                       input logic [IDX_W-1:0] idx);
        t_cursor_report report;
        int pos;
        int i;
        report = '0;
        if (act == ACT_READ) begin
            if (idx < CELLS) begin
                report.rd_cell = screen_cells[idx];
            end
        end else begin
            if (ch == NEWLINE_CODE) begin
                cursor_col = 0;
                cursor_line++;
            end else begin
                pos = cursor_line * COLUMNS + cursor_col;
                if (pos < CELLS) begin
                    screen_cells[pos] = {text_colour, ch};
                end
                cursor_col++;
                if (cursor_col >= COLUMNS) begin
                    cursor_col = 0;
                    cursor_line++;
                end
            end
            if (cursor_line >= ROWS) begin
                for (i = 0; i < CELLS - COLUMNS; i++) begin
                    screen_cells[i] = screen_cells[i + COLUMNS];
                end
                for (i = CELLS - COLUMNS; i < CELLS; i++) begin
                    screen_cells[i] = {text_colour, BLANK_CODE};
                end
                cursor_line = ROWS - 1;
                report.scrolled = 1'b1;
            end
        end
        report.col = cursor_col[COL_W-1:0];
        report.row = cursor_line[ROW_W-1:0];
        return report;
    endfunction

    task automatic send_request(input logic act, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx, input logic typed,
                                input t_cursor_report typed_report);
        t_cursor_report predicted;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_action     <= act;
        i_char_code  <= ch;
        i_cell_index <= idx;
        do begin
            @(posedge i_clk);
        end while (busy);
        predicted = advance_console(act, ch, idx);
        console_reports_due.push_back(typed ? typed_report : predicted);
    endtask

    task automatic send_random_request();
        logic              act;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        int                pick;
        ch  = CHAR_W'($urandom_range(255));
        idx = IDX_W'($urandom_range(2047));
        if ($urandom_range(99) < 40) begin
            act  = ACT_READ;
            pick = $urandom_range(9);
            if (pick < 4) begin
                idx = IDX_W'(cursor_line * COLUMNS + $urandom_range(COLUMNS - 1));
            end else if (pick == 4) begin
                idx = IDX_W'($urandom_range(2047, CELLS));
            end else begin
                idx = IDX_W'($urandom_range(CELLS - 1));
            end
        end else begin
            act = ACT_PUT;
            if ($urandom_range(99) < 5) begin
                ch = NEWLINE_CODE;
            end
        end
        send_request(act, ch, idx, 1'b0, '0);
    endtask

    task automatic drain_console();
        start <= 1'b0;
        while (console_reports_due.size() != 0 || busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic load_colour(input logic [CHAR_W-1:0] colour);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= colour;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        text_colour = colour;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (console_reports_due.size() == 0) begin
                $display("%0t: result with none expected: col %0d row %0d scrolled %0d cell %h",
                         $time, o_cursor_column, o_cursor_row, o_scrolled, o_read_cell);
                fail_count++;
            end else begin
                oldest_report = console_reports_due.pop_front();
                if (o_cursor_column !== oldest_report.col) begin
                    $display("%0t: cursor_column expected %0d actual %0d",
                             $time, oldest_report.col, o_cursor_column);
                    fail_count++;
                end
                if (o_cursor_row !== oldest_report.row) begin
                    $display("%0t: cursor_row expected %0d actual %0d",
                             $time, oldest_report.row, o_cursor_row);
                    fail_count++;
                end
                if (o_scrolled !== oldest_report.scrolled) begin
                    $display("%0t: scrolled expected %0d actual %0d",
                             $time, oldest_report.scrolled, o_scrolled);
                    fail_count++;
                end
                if (o_read_cell !== oldest_report.rd_cell) begin
                    $display("%0t: read_cell expected %h actual %h",
                             $time, oldest_report.rd_cell, o_read_cell);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int i;
        int phase;
        logic [CHAR_W-1:0] colour;
        for (i = 0; i < CELLS; i++) begin
            screen_cells[i] = BLANK_RESET;
        end
        cursor_col  = 0;
        cursor_line = 0;
        text_colour = RESET_COLOR;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < ROWS_DIRECTED; i++) begin
            send_request(directed_requests[i].act, directed_requests[i].ch,
                         directed_requests[i].idx, directed_requests[i].typed,
                         directed_requests[i].want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            drain_console();
            case (phase)
                0: colour = 8'h00;
                1: colour = 8'hFF;
                2: colour = 8'h1E;
                default: colour = CHAR_W'($urandom_range(255));
            endcase
            load_colour(colour);
            idle_pct = (phase == 2) ? 0 : 32;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                send_random_request();
            end
        end

        drain_console();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tmcw_pkg.sv
hdl/tmcw_ram.sv
hdl/tmcw_ctrl.sv
hdl/tmcw_datapath.sv
hdl/text_mode_console_writer_unit.sv
verif/testbench.sv
